// ===== sv/wma_pkg.sv =====
package wma_pkg;

  localparam int FIELD_W         = 10;
  localparam int TIME_W          = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int OUT_DATA_W      = ((2 * FIELD_W + 7) / 8) * 8;

  localparam int DEF_DEPTH       = 1024;
  localparam int DEF_SAMPLE_BITS = 10;

  localparam logic              RST_WINDOW_MODE  = 1'b0;
  localparam logic [TIME_W-1:0] RST_WINDOW_TIME  = 32'd10000;
  localparam logic [FIELD_W-1:0] RST_WINDOW_COUNT = 10'd10;
  localparam logic [FIELD_W-1:0] RST_MIN_CHANGE   = 10'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_MODE  = 2'd0,
    REG_WINDOW_TIME  = 2'd1,
    REG_WINDOW_COUNT = 2'd2,
    REG_MIN_CHANGE   = 2'd3
  } cfg_reg_t;

  localparam logic MODE_BY_TIME  = 1'b0;
  localparam logic MODE_BY_COUNT = 1'b1;

endpackage

// ===== sv/windowed_moving_average.sv =====
// Windowed moving average of timestamped converter samples.
// The in_ channel takes one sample transaction: in_tdata carries the sample and
// its microsecond timestamp, in_tuser selects a gated request, which adds the
// sample only if it differs from the last added sample by at least min_change.
// Every input transaction produces exactly one out_ transaction with the rounded
// window mean, the number of samples held and a flag telling whether the sample
// was added. The cfg_ channel writes the four window registers; it is always
// ready and must only be used while no transaction is in flight.
// An added sample is stored and the window checked for evictions before the mean is
// formed; a gated request that is not taken goes straight to the divider, and every
// evicted sample adds a read: each eviction reads the oldest entry through the single
// registered read port of the sample memory, and the mean comes from a shared
// restoring divider producing one quotient bit per cycle. in_tready is high only while
// the sequencer is idle, so the next sample is accepted at the earliest in the cycle
// after the result is loaded.
// The result sits in an output register; a stalled receiver holds it while the
// next sample is already accepted, and the sequencer waits at its end until the
// register is free. Reset empties the window and restores the register
// defaults; the memory itself needs no clearing.
module windowed_moving_average #(
  parameter int DEPTH       = wma_pkg::DEF_DEPTH,
  parameter int SAMPLE_BITS = wma_pkg::DEF_SAMPLE_BITS,
  localparam int IN_DATA_W  = ((SAMPLE_BITS + wma_pkg::TIME_W + 7) / 8) * 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wma_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wma_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // Fields from bit 0 up: sample, timestamp_us, zero padding.
  input  logic [IN_DATA_W-1:0]                in_tdata,
  // Fields: req_type.
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // Fields from bit 0 up: average, sample_count, zero padding.
  output logic [wma_pkg::OUT_DATA_W-1:0]      out_tdata,
  // Fields: was_added.
  output logic                                out_tuser
);

  localparam int FW     = wma_pkg::FIELD_W;
  localparam int TW     = wma_pkg::TIME_W;
  localparam int ODW    = wma_pkg::OUT_DATA_W;
  localparam int SB     = SAMPLE_BITS;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = IDX_W;
  localparam int SUM_W  = SB + CNT_W;
  localparam int NUM_W  = SUM_W + 2;
  localparam int D_W    = CNT_W + 1;
  localparam int STEP_W = $clog2(SB);
  localparam int RAM_W  = SB + TW;
  localparam int CMP_W  = 32;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PRE  = 8'b0000_0010,
    S_WAIT = 8'b0000_0100,
    S_EVAL = 8'b0000_1000,
    S_PUSH = 8'b0001_0000,
    S_DSET = 8'b0010_0000,
    S_DIV  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic                mode_r, mode_nxt;
  logic [TW-1:0]       wtime_r, wtime_nxt;
  logic [FW-1:0]       wcount_r, wcount_nxt;
  logic [FW-1:0]       minchg_r, minchg_nxt;
  logic [IDX_W-1:0]    newest_r, newest_nxt;
  logic [IDX_W-1:0]    oldest_r, oldest_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [SUM_W-1:0]    sum_r, sum_nxt;
  logic [SB-1:0]       last_r, last_nxt;
  logic                pre_r, pre_nxt;
  logic [SB-1:0]       s_r, s_nxt;
  logic [TW-1:0]       t_r, t_nxt;
  logic                added_r, added_nxt;
  logic [D_W-1:0]      rem_r, rem_nxt;
  logic [SB-1:0]       quo_r, quo_nxt;
  logic [STEP_W-1:0]   step_r, step_nxt;
  logic                out_tvalid_r, out_tvalid_nxt;
  logic [ODW-1:0]      out_tdata_r, out_tdata_nxt;
  logic                out_tuser_r, out_tuser_nxt;

  logic                ram_we;
  logic [RAM_W-1:0]    ram_rdata;
  logic [SB-1:0]       in_sample;
  logic [TW-1:0]       in_time;
  logic [SB-1:0]       diff;
  logic                take;
  logic [SB-1:0]       rd_sample;
  logic [TW-1:0]       rd_time;
  logic [TW-1:0]       age;
  logic                evict;
  logic [NUM_W-1:0]    num;
  logic [D_W-1:0]      divisor;
  logic [D_W:0]        trial;
  logic                trial_ge;
  logic [FW-1:0]       avg_field;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign in_sample = in_tdata[SB-1:0];
  assign in_time   = in_tdata[SB +: TW];
  assign rd_sample = ram_rdata[SB-1:0];
  assign rd_time   = ram_rdata[SB +: TW];

  wma_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (newest_r),
    .wdata ({t_r, s_r}),
    .raddr (oldest_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    diff      = (in_sample > last_r) ? in_sample - last_r : last_r - in_sample;
    take      = !in_tuser || (CMP_W'(diff) >= CMP_W'(minchg_r));
    age       = t_r - rd_time;
    if (mode_r == wma_pkg::MODE_BY_COUNT) begin
      evict = CMP_W'(count_r) > CMP_W'(wcount_r);
    end else begin
      evict = (count_r != '0) && (age > wtime_r);
    end
    evict     = evict || pre_r;
    num       = NUM_W'({sum_r, 1'b0}) + NUM_W'(count_r);
    divisor   = {count_r, 1'b0};
    trial     = {rem_r, quo_r[SB-1]};
    trial_ge  = trial >= {1'b0, divisor};
    avg_field = (count_r == '0) ? '0 : FW'(quo_r);
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    wtime_nxt      = wtime_r;
    wcount_nxt     = wcount_r;
    minchg_nxt     = minchg_r;
    newest_nxt     = newest_r;
    oldest_nxt     = oldest_r;
    count_nxt      = count_r;
    sum_nxt        = sum_r;
    last_nxt       = last_r;
    pre_nxt        = pre_r;
    s_nxt          = s_r;
    t_nxt          = t_r;
    added_nxt      = added_r;
    rem_nxt        = rem_r;
    quo_nxt        = quo_r;
    step_nxt       = step_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    ram_we         = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        wma_pkg::REG_WINDOW_MODE:  mode_nxt   = cfg_data[0];
        wma_pkg::REG_WINDOW_TIME:  wtime_nxt  = cfg_data[TW-1:0];
        wma_pkg::REG_WINDOW_COUNT: wcount_nxt = cfg_data[FW-1:0];
        wma_pkg::REG_MIN_CHANGE:   minchg_nxt = cfg_data[FW-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          s_nxt     = in_sample;
          t_nxt     = in_time;
          added_nxt = take;
          state_nxt = take ? S_PRE : S_DSET;
        end
      end
      S_PRE: begin
        if (count_r == CNT_W'(DEPTH - 1)) begin
          pre_nxt   = 1'b1;
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        ram_we     = 1'b1;
        sum_nxt    = sum_r + SUM_W'(s_r);
        count_nxt  = count_r + CNT_W'(1);
        newest_nxt = (newest_r == IDX_W'(DEPTH - 1)) ? '0 : newest_r + IDX_W'(1);
        last_nxt   = s_r;
        state_nxt  = S_WAIT;
      end
      S_WAIT: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (evict) begin
          sum_nxt    = sum_r - SUM_W'(rd_sample);
          count_nxt  = count_r - CNT_W'(1);
          oldest_nxt = (oldest_r == IDX_W'(DEPTH - 1)) ? '0 : oldest_r + IDX_W'(1);
        end
        if (pre_r) begin
          pre_nxt   = 1'b0;
          state_nxt = S_PUSH;
        end else if (evict) begin
          state_nxt = S_WAIT;
        end else begin
          state_nxt = S_DSET;
        end
      end
      S_DSET: begin
        rem_nxt   = num[SB +: D_W];
        quo_nxt   = num[SB-1:0];
        step_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        rem_nxt  = trial_ge ? D_W'(trial - {1'b0, divisor}) : D_W'(trial);
        quo_nxt  = {quo_r[SB-2:0], trial_ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(SB - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = ODW'({FW'(count_r), avg_field});
          out_tuser_nxt  = added_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= wma_pkg::RST_WINDOW_MODE;
      wtime_r      <= wma_pkg::RST_WINDOW_TIME;
      wcount_r     <= wma_pkg::RST_WINDOW_COUNT;
      minchg_r     <= wma_pkg::RST_MIN_CHANGE;
      newest_r     <= '0;
      oldest_r     <= '0;
      count_r      <= '0;
      sum_r        <= '0;
      last_r       <= '0;
      pre_r        <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      wtime_r      <= wtime_nxt;
      wcount_r     <= wcount_nxt;
      minchg_r     <= minchg_nxt;
      newest_r     <= newest_nxt;
      oldest_r     <= oldest_nxt;
      count_r      <= count_nxt;
      sum_r        <= sum_nxt;
      last_r       <= last_nxt;
      pre_r        <= pre_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r         <= s_nxt;
    t_r         <= t_nxt;
    added_r     <= added_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    step_r      <= step_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

endmodule

// ===== sv/wma_ram.sv =====
module wma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
